// ===== sv/sosi_pkg.sv =====
// ----------------------------------------------------------------------------
// sosi_pkg
// Shared widths, status codes and cell flag type for the sorted offset set.
// ----------------------------------------------------------------------------
package sosi_pkg;

    localparam int OFFSET_W     = 63;
    localparam int STATUS_W     = 2;
    localparam int HELD_W       = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Compare result of one cell against the key under test.
    typedef struct packed {
        logic lt;   // valid entry smaller than the key
        logic eq;   // valid entry equal to the key
    } cell_flags_t;

endpackage

// ===== sv/sosi_cell.sv =====
// ----------------------------------------------------------------------------
// sosi_cell
// One slot of the sorted table: compares its entry with the key and, on an
// insert, keeps its entry, takes the key or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module sosi_cell (
    input  logic                         aclk,
    input  logic [sosi_pkg::OFFSET_W-1:0] key,
    input  logic                         slot_valid,
    input  logic                         write_en,
    input  logic [sosi_pkg::OFFSET_W-1:0] left_entry,
    input  logic                         left_lt,
    output logic [sosi_pkg::OFFSET_W-1:0] entry,
    output sosi_pkg::cell_flags_t        flags
);
    import sosi_pkg::*;

    logic [OFFSET_W-1:0] entry_reg;
    logic [OFFSET_W-1:0] entry_next;

    assign flags.lt = slot_valid && (entry_reg < key);
    assign flags.eq = slot_valid && (entry_reg == key);
    assign entry    = entry_reg;

    // Smaller entries stay put; the first slot not smaller takes the key and
    // every slot above it takes the entry of its left neighbor.
    always_comb begin
        entry_next = entry_reg;
        if (write_en && !flags.lt) begin
            entry_next = left_lt ? key : left_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/sorted_offset_set_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_offset_set_insert
// Visited set of file offsets held as an ascending row of compare cells.
// ----------------------------------------------------------------------------
// Each slave transfer carries one offset in s_tdata and a clear request in
// s_tuser. The block answers each one with exactly one master transfer that
// gives the status (inserted, already present, or table full) and the number
// of offsets held afterwards. A clear request empties the table before the
// offset is looked up. The row of CAPACITY cells compares every stored entry
// with the key at once and shifts the larger entries up by one slot in the
// same cycle. The edge of the slave transfer captures the item; a later edge,
// once the output register is free, compares, updates the table and loads
// the output register. The block takes a new item only after the previous
// one has left the capture register and passed the compare-and-shift step
// through the cell row.
// Reset clears the entry count and all handshake state; stored entries are
// left as they are and are ignored until written again.
// When the receiver stalls, the result waits in the output register; one
// further item may be captured, and it waits until the output register is
// free before it updates the table.
// ----------------------------------------------------------------------------
module sorted_offset_set_insert #(
    parameter int CAPACITY = sosi_pkg::DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] offset, [63] zero
    input  logic [0:0]  s_tuser,   // [0] clear_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [8:2] entries_held, [15:9] zero
);
    import sosi_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                busy_reg;
    logic                busy_next;
    logic [OFFSET_W-1:0] key_reg;
    logic                clear_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;

    logic                s_xfer;
    logic                out_free;
    logic                execute;
    logic [CNT_W-1:0]    eff_count;
    logic                hit;
    logic                full;
    logic                write_en;
    logic [CNT_W+HELD_W-1:0] held_ext;

    logic [OFFSET_W-1:0] entries [CAPACITY];
    cell_flags_t         flags   [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;

    assign s_tready = !busy_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign execute  = busy_reg && out_free;

    assign eff_count = clear_reg ? '0 : count_reg;
    assign full      = (eff_count == CNT_W'(CAPACITY));
    assign hit       = |eq_vec;
    assign write_en  = execute && !hit && !full;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [OFFSET_W-1:0] left_entry;
            logic                left_lt;
            if (gi == 0) begin : g_first
                assign left_entry = key_reg;
                assign left_lt    = 1'b1;
            end else begin : g_rest
                assign left_entry = entries[gi-1];
                assign left_lt    = flags[gi-1].lt;
            end
            sosi_cell u_cell (
                .aclk       (aclk),
                .key        (key_reg),
                .slot_valid (CNT_W'(gi) < eff_count),
                .write_en   (write_en),
                .left_entry (left_entry),
                .left_lt    (left_lt),
                .entry      (entries[gi]),
                .flags      (flags[gi])
            );
            assign eq_vec[gi] = flags[gi].eq;
        end
    endgenerate

    always_comb begin
        busy_next      = busy_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        held_next      = held_reg;
        held_ext       = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (execute) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            if (hit) begin
                status_next = ST_PRESENT;
                count_next  = eff_count;
            end else if (full) begin
                status_next = ST_FULL;
                count_next  = eff_count;
            end else begin
                status_next = ST_INSERTED;
                count_next  = eff_count + CNT_W'(1);
            end
            // The held count is reported modulo 128.
            held_ext  = {{HELD_W{1'b0}}, count_next};
            held_next = held_ext[HELD_W-1:0];
        end
        if (s_xfer) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        held_reg   <= held_next;
        if (s_xfer) begin
            key_reg   <= s_tdata[OFFSET_W-1:0];
            clear_reg <= s_tuser[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - HELD_W - STATUS_W){1'b0}}, held_reg, status_reg};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted offset set with duplicate detection.
// ----------------------------------------------------------------------------
// Offsets are streamed into the block with random gaps. A shadow copy of the
// sorted table gives the expected status and entry count of every transfer.
// The stimulus covers edge offsets, filling the table and probing it while it
// is full, and random runs that mix dense pools, present entries, their
// neighbors and clear requests. It ends with a back-to-back stretch.
// ----------------------------------------------------------------------------
module testbench;
    import sosi_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [OFFSET_W-1:0] MAX_OFFSET = {OFFSET_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HELD_W-1:0]   held;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [62:0] offset, [63] zero
    logic [0:0]  s_tuser  = '0;    // [0] clear_first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [1:0] status, [8:2] entries_held, [15:9] zero

    // Shadow of the table and the results still owed by the block.
    logic [OFFSET_W-1:0] shadow_set [CAPACITY];
    int                  shadow_count = 0;
    outcome_t            outcome_q [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    bit gaps_enabled   = 1'b1;

    sorted_offset_set_insert uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Looks the key up in the shadow table, inserts it when it is new and
    // there is room, and returns what the block should report.
    function automatic outcome_t set_insert_outcome(logic [OFFSET_W-1:0] key, logic clear);
        outcome_t r;
        int       pos;
        bit       hit;
        if (clear) begin
            shadow_count = 0;
        end
        pos = shadow_count;
        hit = 1'b0;
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_set[i] >= key) begin
                pos = i;
                hit = (shadow_set[i] == key);
                break;
            end
        end
        if (hit) begin
            r.status = ST_PRESENT;
        end else if (shadow_count >= CAPACITY) begin
            r.status = ST_FULL;
        end else begin
            for (int j = shadow_count; j > pos; j--) begin
                shadow_set[j] = shadow_set[j-1];
            end
            shadow_set[pos] = key;
            shadow_count++;
            r.status = ST_INSERTED;
        end
        r.held = HELD_W'(shadow_count);
        return r;
    endfunction

    function automatic logic [OFFSET_W-1:0] rand_offset();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[OFFSET_W-1:0];
    endfunction

    // Offset drawn according to the flavor of the current run.
    function automatic logic [OFFSET_W-1:0] pick_offset(int mode, logic [OFFSET_W-1:0] base);
        logic [OFFSET_W-1:0] hit_key;
        case (mode)
            0: begin
                return rand_offset();
            end
            1: begin
                return base + OFFSET_W'($urandom_range(0, 63));
            end
            2: begin
                if (shadow_count == 0) begin
                    return base;
                end
                hit_key = shadow_set[$urandom_range(0, shadow_count - 1)];
                case ($urandom_range(0, 2))
                    0: return hit_key - 1'b1;
                    1: return hit_key + 1'b1;
                    default: return hit_key;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    return OFFSET_W'($urandom_range(0, 20));
                end
                return MAX_OFFSET - OFFSET_W'($urandom_range(0, 20));
            end
        endcase
    endfunction

    task automatic send_offset(input logic [OFFSET_W-1:0] key, input logic clear);
        int gap;
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, key};
        s_tuser  <= clear;
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(set_insert_outcome(key, clear));
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    // Result checker, receiver stalls and the watchdog.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with none expected: status %0d held %0d",
                             $time, m_tdata[1:0], m_tdata[8:2]);
                    mismatch_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, m_tdata[1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[8:2] !== want.held) begin
                        $display("%0t: entries_held mismatch: expected %0d actual %0d",
                                 $time, want.held, m_tdata[8:2]);
                        mismatch_count++;
                    end
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    task automatic test_boundary_offsets();
        send_offset('0, 1'b1);
        send_offset('0, 1'b0);                // duplicate of the smallest offset
        send_offset(MAX_OFFSET, 1'b0);
        send_offset(MAX_OFFSET, 1'b0);        // duplicate of the largest offset
        send_offset(MAX_OFFSET - 1'b1, 1'b0); // goes between the two ends
        send_offset(OFFSET_W'(1), 1'b0);
        send_offset({1'b1, {(OFFSET_W-1){1'b0}}}, 1'b0);
        send_offset({1'b0, {(OFFSET_W-1){1'b1}}}, 1'b0);
        send_offset(OFFSET_W'(1), 1'b0);
        send_offset('0, 1'b1);                // clear, then the old offset is new again
        send_offset('0, 1'b1);
        send_offset(MAX_OFFSET, 1'b1);
        send_offset(OFFSET_W'(5), 1'b0);
        send_offset(OFFSET_W'(3), 1'b0);      // insert at the front
        send_offset(OFFSET_W'(4), 1'b0);      // insert in the middle
        send_offset(OFFSET_W'(5), 1'b0);
    endtask

    task automatic test_fill_and_full();
        logic [OFFSET_W-1:0] key;
        // First fill in random order, second in descending order so every
        // new offset lands at the front and shifts the whole row.
        for (int pass = 0; pass < 2; pass++) begin
            key = MAX_OFFSET - OFFSET_W'($urandom_range(0, 1000));
            send_offset(pass == 0 ? rand_offset() : key, 1'b1);
            while (shadow_count < CAPACITY) begin
                key = key - OFFSET_W'($urandom_range(1, 4));
                send_offset(pass == 0 ? rand_offset() : key, 1'b0);
            end
            for (int k = 0; k < 8; k++) begin
                if (k % 2 == 0) begin
                    send_offset(pick_offset(k % 4 == 0 ? 0 : 3, '0), 1'b0);
                end else begin
                    // A present offset still reports a duplicate when full.
                    send_offset(shadow_set[$urandom_range(0, CAPACITY - 1)], 1'b0);
                end
            end
        end
        send_offset(rand_offset(), 1'b1);
    endtask

    task automatic test_mixed_runs(input int count);
        int                  run_len;
        int                  mode;
        logic [OFFSET_W-1:0] base;
        int                  stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            run_len = $urandom_range(1, 80);
            mode    = $urandom_range(0, 3);
            base    = rand_offset();
            send_offset(pick_offset(mode, base), 1'($urandom_range(0, 1)));
            for (int k = 1; k < run_len && items_sent < stop_at; k++) begin
                send_offset(pick_offset($urandom_range(0, 4) == 0 ? 2 : mode, base),
                            $urandom_range(0, 29) == 0);
            end
        end
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 4; k++) begin
            test_mixed_runs(10);
            drain_results();
        end
    endtask

    task automatic test_streaming_tail();
        gaps_enabled = 1'b0;
        test_mixed_runs(100);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_boundary_offsets();
        test_fill_and_full();
        test_mixed_runs(380);
        test_drain_pause();
        test_streaming_tail();
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && outcome_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
